>>> rtl/first_match_prefix_route_table_top_defines.svh
// ----------------------------------------------------------------------------
// Route table assertion macros
// Shared concurrent assertion shorthands, clocked on i_clk and held off
// while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_MATCH_PREFIX_ROUTE_TABLE_TOP_DEFINES_SVH
`define FIRST_MATCH_PREFIX_ROUTE_TABLE_TOP_DEFINES_SVH

// Same-cycle implication.
`define FMPRT_ASSERT_IMP(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error("route table check failed");

// Next-cycle implication.
`define FMPRT_ASSERT_NXT(name, cond, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error("route table sequencing check failed");

`endif

>>> rtl/fmprt_pkg.sv
// ----------------------------------------------------------------------------
// Route table package
// Sizes, operation codes and the control bundle broadcast to the route cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fmprt_pkg;

    localparam int MAX_ROUTES = 16;
    localparam int MAX_PREFIX = 64;

    localparam int OP_W   = 2;
    localparam int SLOT_W = 4;
    localparam int POS_W  = 6;
    localparam int BYTE_W = 8;
    localparam int METH_W = 8;
    localparam int LEN_W  = 7;
    localparam int CNT_W  = 7;
    localparam int ACT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_HEADER = 2'd0,
        OP_PREFIX = 2'd1,
        OP_PATH   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Broadcast to every cell; write enables travel separately per cell.
    typedef struct packed {
        logic [POS_W-1:0]  wr_pos;
        logic [BYTE_W-1:0] wr_byte;
        logic [METH_W-1:0] wr_method;
        logic [LEN_W-1:0]  wr_length;
        logic              rd_en;
        logic [POS_W-1:0]  rd_addr;
        logic              cmp_en;
        logic [BYTE_W-1:0] cmp_byte;
        logic [CNT_W-1:0]  cmp_pos;
        logic              finish;
        logic [METH_W-1:0] req_method;
        logic [CNT_W-1:0]  final_count;
    } t_cell_ctl;

endpackage

>>> rtl/fmprt_if.sv
// ----------------------------------------------------------------------------
// Route table channel interfaces
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fmprt_in_if;
    logic                              valid;
    logic                              ready;
    logic [fmprt_pkg::OP_W-1:0]        operation;
    logic [fmprt_pkg::SLOT_W-1:0]      route_slot;
    logic [fmprt_pkg::POS_W-1:0]       byte_position;
    logic [fmprt_pkg::BYTE_W-1:0]      byte_value;
    logic [fmprt_pkg::METH_W-1:0]      route_method_code;
    logic [fmprt_pkg::LEN_W-1:0]       route_prefix_length;
    logic [fmprt_pkg::METH_W-1:0]      request_method;
    logic                              has_byte;
    logic                              last_byte;

    modport source (
        output valid, operation, route_slot, byte_position, byte_value,
               route_method_code, route_prefix_length, request_method,
               has_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, operation, route_slot, byte_position, byte_value,
               route_method_code, route_prefix_length, request_method,
               has_byte, last_byte,
        output ready
    );
endinterface

interface fmprt_out_if;
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic [fmprt_pkg::SLOT_W-1:0]  route_index;

    modport source (output valid, hit, route_index, input ready);
    modport sink   (input valid, hit, route_index, output ready);
endinterface

>>> rtl/fmprt_cell.sv
// ----------------------------------------------------------------------------
// Route cell
// Holds one route: header, prefix bytes and the running match flag. Passes
// the first-match claim on to the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fmprt_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_hdr_we,
    input  logic                  i_byte_we,
    input  logic                  i_active,
    input  fmprt_pkg::t_cell_ctl  i_ctl,
    input  logic                  i_claim,
    output logic                  o_claim,
    output logic                  o_sel
);

    logic [fmprt_pkg::BYTE_W-1:0] r_mem [fmprt_pkg::MAX_PREFIX];
    logic [fmprt_pkg::BYTE_W-1:0] r_rdata;
    logic [fmprt_pkg::METH_W-1:0] r_method;
    logic [fmprt_pkg::LEN_W-1:0]  r_length;
    logic                         r_match;
    logic                         r_qual;
    logic                         n_match;
    logic                         n_qual;
    logic                         mismatch;

    always_ff @(posedge i_clk) begin
        if (i_byte_we) begin
            r_mem[i_ctl.wr_pos] <= i_ctl.wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_ctl.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hdr_we) begin
            r_method <= i_ctl.wr_method;
            r_length <= i_ctl.wr_length;
        end
    end

    // Only positions inside the route's prefix can break the match.
    assign mismatch = i_ctl.cmp_en && (i_ctl.cmp_pos < r_length) &&
                      (r_rdata != i_ctl.cmp_byte);
    assign n_match  = r_match && !mismatch;
    assign n_qual   = i_active && n_match && (r_length <= i_ctl.final_count) &&
                      ((r_method == '0) || (r_method == i_ctl.req_method));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b1;
            r_qual  <= 1'b0;
        end else if (i_ctl.finish) begin
            r_match <= 1'b1;
            r_qual  <= n_qual;
        end else begin
            r_match <= n_match;
        end
    end

    assign o_sel   = r_qual && !i_claim;
    assign o_claim = i_claim || r_qual;

endmodule

>>> rtl/first_match_prefix_route_table_top.sv
// ----------------------------------------------------------------------------
// First-match prefix route table
// Row of route cells matching a streamed request path against stored
// route prefixes and reporting the lowest matching route.
// ----------------------------------------------------------------------------
// Usage: the request channel i_req carries three kinds of transaction.
// A header transaction writes a route's method (zero accepts any method) and
// its prefix length, a prefix transaction writes one prefix byte, and a path
// transaction streams one request path byte. Each route lives in its own
// cell with a private 64-byte prefix memory, so every path byte is checked
// against all routes at once, one byte per cycle.
// Path bytes are taken every cycle; the only pause is the time after the
// final path transaction while the cells settle their verdicts and hand them
// to the response register, plus any time the result waits because the
// response register is still full. The final path transaction yields one
// response on o_rsp: hit and the lowest qualifying slot below active_routes,
// via stage one and the cell verdicts. The cells' first-match claim ripples
// down the row to pick that slot. If o_rsp is stalled, the response register
// holds its result and one further result can wait behind it, after which
// i_req.ready stays low. Write the active route count only while the block
// is idle, through i_cfg_we/i_cfg_wdata; the block does not enforce this.
// Reset (synchronous, active low) clears the active count, the path counter
// and all pipeline valids and sets every match flag; the route headers and
// prefix bytes must be written before they are used.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "first_match_prefix_route_table_top_defines.svh"

module first_match_prefix_route_table_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fmprt_pkg::ACT_W-1:0]   i_cfg_wdata,
    fmprt_in_if.sink                      i_req,
    fmprt_out_if.source                   o_rsp
);

    localparam int NR = fmprt_pkg::MAX_ROUTES;

    logic [fmprt_pkg::ACT_W-1:0]  r_active;
    logic [fmprt_pkg::CNT_W-1:0]  r_count;
    logic [fmprt_pkg::CNT_W-1:0]  n_count;

    // Stage one: the path transaction whose prefix bytes are being compared.
    logic                         r_s1_cmp;
    logic                         r_s1_last;
    logic [fmprt_pkg::BYTE_W-1:0] r_s1_byte;
    logic [fmprt_pkg::CNT_W-1:0]  r_s1_pos;
    logic [fmprt_pkg::CNT_W-1:0]  r_s1_final;
    logic [fmprt_pkg::METH_W-1:0] r_s1_method;

    // Verdicts captured in the cells, waiting for the response register.
    logic                         r_q_valid;

    logic                         r_o_valid;
    logic                         r_o_hit;
    logic [fmprt_pkg::SLOT_W-1:0] r_o_index;

    logic                         accept;
    logic                         path_acc;
    logic                         byte_cmp;
    logic                         q_move;
    logic [NR-1:0]                hdr_we;
    logic [NR-1:0]                byte_we;
    logic [NR-1:0]                active;
    logic [NR:0]                  claim;
    logic [NR-1:0]                sel;
    logic [fmprt_pkg::SLOT_W-1:0] sel_index;
    logic [fmprt_pkg::LEN_W-1:0]  clip_len;
    fmprt_pkg::t_cell_ctl         ctl;

    assign i_req.ready = !r_s1_last && !r_q_valid;
    assign accept      = i_req.valid && i_req.ready;
    assign path_acc    = accept && (i_req.operation == fmprt_pkg::OP_PATH);
    assign byte_cmp    = path_acc && i_req.has_byte &&
                         (r_count < fmprt_pkg::CNT_W'(fmprt_pkg::MAX_PREFIX));

    // The path counter moves at acceptance so the next byte reads the next
    // position; it returns to zero with the final path transaction.
    always_comb begin
        n_count = r_count;
        if (path_acc && i_req.last_byte) begin
            n_count = '0;
        end else if (byte_cmp) begin
            n_count = r_count + 1'b1;
        end
    end

    assign clip_len = (i_req.route_prefix_length >
                       fmprt_pkg::LEN_W'(fmprt_pkg::MAX_PREFIX)) ?
                      fmprt_pkg::LEN_W'(fmprt_pkg::MAX_PREFIX) :
                      i_req.route_prefix_length;

    always_comb begin
        for (int i = 0; i < NR; i++) begin
            hdr_we[i]  = accept && (i_req.operation == fmprt_pkg::OP_HEADER) &&
                         (i_req.route_slot == fmprt_pkg::SLOT_W'(i));
            byte_we[i] = accept && (i_req.operation == fmprt_pkg::OP_PREFIX) &&
                         (i_req.route_slot == fmprt_pkg::SLOT_W'(i));
            active[i]  = fmprt_pkg::ACT_W'(i) < r_active;
        end
    end

    always_comb begin
        ctl             = '0;
        ctl.wr_pos      = i_req.byte_position;
        ctl.wr_byte     = i_req.byte_value;
        ctl.wr_method   = i_req.route_method_code;
        ctl.wr_length   = clip_len;
        ctl.rd_en       = byte_cmp;
        ctl.rd_addr     = r_count[fmprt_pkg::POS_W-1:0];
        ctl.cmp_en      = r_s1_cmp;
        ctl.cmp_byte    = r_s1_byte;
        ctl.cmp_pos     = r_s1_pos;
        ctl.finish      = r_s1_last;
        ctl.req_method  = r_s1_method;
        ctl.final_count = r_s1_final;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_s1_cmp  <= 1'b0;
            r_s1_last <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_s1_cmp  <= byte_cmp;
            r_s1_last <= path_acc && i_req.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (path_acc) begin
            r_s1_byte   <= i_req.byte_value;
            r_s1_pos    <= r_count;
            r_s1_final  <= byte_cmp ? (r_count + 1'b1) : r_count;
            r_s1_method <= i_req.request_method;
        end
    end

    // Row of route cells; the claim enters at slot zero.
    assign claim[0] = 1'b0;

    for (genvar g = 0; g < NR; g++) begin : g_cell
        fmprt_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_hdr_we  (hdr_we[g]),
            .i_byte_we (byte_we[g]),
            .i_active  (active[g]),
            .i_ctl     (ctl),
            .i_claim   (claim[g]),
            .o_claim   (claim[g+1]),
            .o_sel     (sel[g])
        );
    end

    always_comb begin
        sel_index = '0;
        for (int i = 0; i < NR; i++) begin
            if (sel[i]) begin
                sel_index = sel_index | fmprt_pkg::SLOT_W'(i);
            end
        end
    end

    assign q_move = r_q_valid && (!r_o_valid || o_rsp.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (r_s1_last) begin
                r_q_valid <= 1'b1;
            end else if (q_move) begin
                r_q_valid <= 1'b0;
            end
            if (q_move) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_move) begin
            r_o_hit   <= claim[NR];
            r_o_index <= sel_index;
        end
    end

    assign o_rsp.valid       = r_o_valid;
    assign o_rsp.hit         = r_o_hit;
    assign o_rsp.route_index = r_o_index;

    `FMPRT_ASSERT_IMP(a_sel_onehot, 1'b1, $onehot0(sel))
    `FMPRT_ASSERT_IMP(a_count_range, 1'b1,
        r_count <= fmprt_pkg::CNT_W'(fmprt_pkg::MAX_PREFIX))
    `FMPRT_ASSERT_NXT(a_last_to_q, r_s1_last, r_q_valid && (r_count == '0))
    `FMPRT_ASSERT_IMP(a_miss_zero, r_q_valid && !claim[NR], sel_index == '0)
    `FMPRT_ASSERT_IMP(a_rsp_source, $rose(r_o_valid), $past(r_q_valid))

endmodule
